[sv/dpf_pkg.sv]
package dpf_pkg;

    // default number of fractional bits of every fixed point value
    localparam int FRAC_BITS_DEF = 16;

    // target mass after reset, about 0.938 at 16 fractional bits
    localparam logic [19:0] MASS_RESET = 20'd61473;

    // status codes of a result item
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_NOSEL  = 3'd1;
    localparam logic [2:0] ST_Q2     = 3'd2;
    localparam logic [2:0] ST_EPSDEN = 3'd3;
    localparam logic [2:0] ST_ADEN   = 3'd4;
    localparam logic [2:0] ST_NEGRAD = 3'd5;

    // side data carried through the t divider
    typedef struct packed {
        logic signed [17:0] y;
        logic [35:0]        y2;
        logic [2:0]         st;
    } t_tag_t;

    // side data carried through the epsilon divider
    typedef struct packed {
        logic        neg;
        logic        ovf;
        logic [35:0] y2;
        logic [2:0]  st;
    } t_tag_eps;

    // side data carried through the A divider
    typedef struct packed {
        logic               neg;
        logic               ovf;
        logic signed [31:0] eps;
        logic [2:0]         st;
    } t_tag_a;

    // side data carried through the square root lanes
    typedef struct packed {
        logic signed [31:0] eps;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic [31:0]        ma;
        logic               sa;
        logic [2:0]         st;
        logic [2:0]         neg;
    } t_side;

endpackage

[sv/dpf_div.sv]
module dpf_div #(
    parameter int NW = 62,
    parameter int DW = 23,
    parameter int QW = 62,
    parameter int TW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    input  logic [TW-1:0] i_tag,
    output logic          o_valid,
    output logic [QW-1:0] o_quotient,
    output logic [TW-1:0] o_tag
);

    // restoring divider, one quotient bit per stage; the caller keeps
    // the dividend below the divisor shifted up by QW bits
    localparam int HW = NW - QW;

    logic [DW-1:0] w_rem0;
    logic [DW-1:0] r_rem [QW];
    logic [DW-1:0] r_dvs [QW];
    logic [QW-1:0] r_low [QW];
    logic [QW-1:0] r_quo [QW];
    logic [TW-1:0] r_tag [QW];
    logic          r_vld [QW];

    // initial partial remainder from the upper dividend bits
    generate
        if (HW == 0) begin : g_rem_none
            assign w_rem0 = '0;
        end else if (HW >= DW) begin : g_rem_cut
            assign w_rem0 = i_dividend[QW +: DW];
        end else begin : g_rem_ext
            assign w_rem0 = DW'(i_dividend[NW-1:QW]);
        end
    endgenerate

    generate
        for (genvar k = 0; k < QW; k++) begin : g_stage
            logic [DW-1:0] w_rem_in;
            logic [DW-1:0] w_dvs_in;
            logic [QW-1:0] w_low_in;
            logic [QW-1:0] w_quo_in;
            logic [TW-1:0] w_tag_in;
            logic          w_vld_in;
            logic [DW:0]   w_trial;
            logic [DW:0]   w_diff;

            if (k == 0) begin : g_first
                assign w_rem_in = w_rem0;
                assign w_dvs_in = i_divisor;
                assign w_low_in = i_dividend[QW-1:0];
                assign w_quo_in = '0;
                assign w_tag_in = i_tag;
                assign w_vld_in = i_valid;
            end else begin : g_next
                assign w_rem_in = r_rem[k-1];
                assign w_dvs_in = r_dvs[k-1];
                assign w_low_in = r_low[k-1];
                assign w_quo_in = r_quo[k-1];
                assign w_tag_in = r_tag[k-1];
                assign w_vld_in = r_vld[k-1];
            end

            // bring down one dividend bit and try the subtraction
            assign w_trial = {w_rem_in, w_low_in[QW-1]};
            assign w_diff  = w_trial - {1'b0, w_dvs_in};

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (i_en) begin
                    r_vld[k] <= w_vld_in;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (w_trial >= {1'b0, w_dvs_in}) begin
                        r_rem[k] <= w_diff[DW-1:0];
                        r_quo[k] <= {w_quo_in[QW-2:0], 1'b1};
                    end else begin
                        r_rem[k] <= w_trial[DW-1:0];
                        r_quo[k] <= {w_quo_in[QW-2:0], 1'b0};
                    end
                    r_low[k] <= w_low_in << 1;
                    r_dvs[k] <= w_dvs_in;
                    r_tag[k] <= w_tag_in;
                end
            end
        end
    endgenerate

    assign o_valid    = r_vld[QW-1];
    assign o_quotient = r_quo[QW-1];
    assign o_tag      = r_tag[QW-1];

endmodule

[sv/depolarization_factors.sv]
// Depolarization factors for one kinematics row per item: from Q2, x and y and the
// target mass register it forms epsilon, A, B, C, V and W with FRAC_BITS
// fractional bits, each saturated to 32 bits, plus a status code. The block is
// a pipeline that takes one row per clock while the output is not stalled;
// its depth is set by the three restoring dividers (62, 32 and 32
// stages, one quotient bit each), the 32 stage square root lanes and 18
// arithmetic stages around them. A stall on the output freezes the whole
// pipeline. Write the mass only while no row is in flight.
module depolarization_factors #(
    parameter int FRAC_BITS = dpf_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [19:0]        i_target_mass,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [23:0] i_q2,
    input  logic signed [17:0] i_x_bjorken,
    input  logic signed [17:0] i_y_inelasticity,
    input  logic               i_row_selected,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_epsilon_out,
    output logic signed [31:0] o_factor_a,
    output logic signed [31:0] o_factor_b,
    output logic signed [31:0] o_factor_c,
    output logic signed [31:0] o_factor_v,
    output logic signed [31:0] o_factor_w,
    output logic [2:0]         o_status
);

    localparam logic signed [63:0] ONE   = 64'sd1 <<< FRAC_BITS;
    localparam int                 RDW   = 63 - FRAC_BITS;
    localparam logic [63:0]        LIM   = (64'd1 << RDW) - 64'd1;
    localparam logic [61:0]        T_MAX = 62'd1 << 60;
    localparam int                 SQ_N  = 32;

    // saturate a magnitude with a sign to 32 bits
    function automatic logic signed [31:0] sat_mag(input logic neg, input logic [63:0] m);
        logic signed [31:0] res;
        if (neg) begin
            res = (m > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-m);
        end else begin
            res = (m > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(m);
        end
        return res;
    endfunction

    logic w_en;
    logic [19:0] r_mass;

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mass <= dpf_pkg::MASS_RESET;
        end else if (i_cfg_valid) begin
            r_mass <= i_target_mass;
        end
    end

    // whole pipeline advances unless the output holds an item not taken
    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    // stage 1: magnitudes, early status, M times |x|
    logic [17:0]        w_xmag, w_ymag;
    logic [2:0]         w_st0;
    logic               r_v1;
    logic [37:0]        r1_mx;
    logic [17:0]        r1_my;
    logic signed [17:0] r1_y;
    logic signed [23:0] r1_q;
    logic [2:0]         r1_st;

    assign w_xmag = i_x_bjorken[17] ? 18'(-i_x_bjorken) : 18'(i_x_bjorken);
    assign w_ymag = i_y_inelasticity[17] ? 18'(-i_y_inelasticity) : 18'(i_y_inelasticity);

    always_comb begin
        if (!i_row_selected) begin
            w_st0 = dpf_pkg::ST_NOSEL;
        end else if (i_q2[23] || i_q2 == 24'sd0) begin
            w_st0 = dpf_pkg::ST_Q2;
        end else begin
            w_st0 = dpf_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_mx <= 38'(r_mass) * 38'(w_xmag);
            r1_my <= w_ymag;
            r1_y  <= i_y_inelasticity;
            r1_q  <= i_q2;
            r1_st <= w_st0;
        end
    end

    // stage 2: M |x| |y|
    logic               r_v2;
    logic [55:0]        r2_pm;
    logic [17:0]        r2_my;
    logic signed [17:0] r2_y;
    logic signed [23:0] r2_q;
    logic [2:0]         r2_st;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_pm <= 56'(r1_mx) * 56'(r1_my);
            r2_my <= r1_my;
            r2_y  <= r1_y;
            r2_q  <= r1_q;
            r2_st <= r1_st;
        end
    end

    // stage 3: rescale and saturate u, square of |y|
    logic [55:0]        w_uf;
    logic               r_v3;
    logic [30:0]        r3_u;
    logic [35:0]        r3_y2;
    logic signed [17:0] r3_y;
    logic signed [23:0] r3_q;
    logic [2:0]         r3_st;

    assign w_uf = r2_pm >> (2 * FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_u  <= (w_uf > 56'h7FFF_FFFF) ? 31'h7FFF_FFFF : w_uf[30:0];
            r3_y2 <= 36'(r2_my) * 36'(r2_my);
            r3_y  <= r2_y;
            r3_q  <= r2_q;
            r3_st <= r2_st;
        end
    end

    // stage 4: u squared
    logic              r_v4;
    logic [61:0]       r4_uu;
    logic [22:0]       r4_q;
    dpf_pkg::t_tag_t   r4_tag;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_uu  <= 62'(r3_u) * 62'(r3_u);
            r4_q   <= r3_q[22:0];
            r4_tag <= '{y: r3_y, y2: r3_y2, st: r3_st};
        end
    end

    // t = u^2 / Q2
    logic              d1_vld;
    logic [61:0]       d1_q;
    dpf_pkg::t_tag_t   d1_tag;

    dpf_div #(
        .NW (62),
        .DW (23),
        .QW (62),
        .TW ($bits(dpf_pkg::t_tag_t))
    ) u_div_t (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (r_v4),
        .i_dividend (r4_uu),
        .i_divisor  (r4_q),
        .i_tag      (r4_tag),
        .o_valid    (d1_vld),
        .o_quotient (d1_q),
        .o_tag      (d1_tag)
    );

    // stage 5: cap t
    logic            r_v5;
    logic [60:0]     r5_t;
    dpf_pkg::t_tag_t r5_tag;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_t   <= (d1_q > T_MAX) ? T_MAX[60:0] : d1_q[60:0];
            r5_tag <= d1_tag;
        end
    end

    // stage 6: numerator and denominator of epsilon
    logic signed [63:0] w_y64, w_num, w_den;
    logic               r_v6;
    logic signed [63:0] r6_num, r6_den;
    logic [35:0]        r6_y2;
    logic [2:0]         r6_st;

    assign w_y64 = 64'(r5_tag.y);
    assign w_den = ONE - w_y64 + 64'(r5_tag.y2 >> (FRAC_BITS + 1)) + 64'(r5_t);
    assign w_num = ONE - w_y64 - 64'(r5_t);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_num <= w_num;
            r6_den <= w_den;
            r6_y2  <= r5_tag.y2;
            if (r5_tag.st == dpf_pkg::ST_OK && w_den == 64'sd0) begin
                r6_st <= dpf_pkg::ST_EPSDEN;
            end else begin
                r6_st <= r5_tag.st;
            end
        end
    end

    // stage 7: magnitudes for the epsilon division
    logic        r_v7;
    logic [61:0] r7_ua, r7_ub;
    logic        r7_neg;
    logic [35:0] r7_y2;
    logic [2:0]  r7_st;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_ua  <= r6_num[63] ? 62'(-r6_num) : 62'(r6_num);
            r7_ub  <= r6_den[63] ? 62'(-r6_den) : 62'(r6_den);
            r7_neg <= r6_num[63] ^ r6_den[63];
            r7_y2  <= r6_y2;
            r7_st  <= r6_st;
        end
    end

    // stage 8: quotient too large for 32 bits
    logic [61+FRAC_BITS:0] w_dvd_e;
    logic                  w_ovf_e;
    logic                  r_v8;
    logic [61:0]           r8_ua, r8_ub;
    dpf_pkg::t_tag_eps     r8_tag;

    assign w_dvd_e = {r7_ua, {FRAC_BITS{1'b0}}};
    assign w_ovf_e = 94'(w_dvd_e) >= {r7_ub, 32'b0};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_ua  <= r7_ua;
            r8_ub  <= r7_ub;
            r8_tag <= '{neg: r7_neg, ovf: w_ovf_e, y2: r7_y2, st: r7_st};
        end
    end

    // epsilon magnitude
    logic              d2_vld;
    logic [31:0]       d2_q;
    dpf_pkg::t_tag_eps d2_tag;

    dpf_div #(
        .NW (62 + FRAC_BITS),
        .DW (62),
        .QW (32),
        .TW ($bits(dpf_pkg::t_tag_eps))
    ) u_div_eps (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (r_v8),
        .i_dividend ({r8_ua, {FRAC_BITS{1'b0}}}),
        .i_divisor  (r8_ub),
        .i_tag      (r8_tag),
        .o_valid    (d2_vld),
        .o_quotient (d2_q),
        .o_tag      (d2_tag)
    );

    // stage 9: saturate epsilon
    logic               r_v9;
    logic signed [31:0] r9_eps;
    logic [35:0]        r9_y2;
    logic [2:0]         r9_st;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r9_eps <= sat_mag(d2_tag.neg, d2_tag.ovf ? '1 : 64'(d2_q));
            r9_y2  <= d2_tag.y2;
            r9_st  <= d2_tag.st;
        end
    end

    // stage 10: denominator of A
    logic signed [34:0] w_aden;
    logic               r_v10;
    logic signed [34:0] r10_aden;
    logic [35:0]        r10_ua;
    logic signed [31:0] r10_eps;
    logic [2:0]         r10_st;

    assign w_aden = (35'(ONE) <<< 1) - (35'(r9_eps) <<< 1);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r10_aden <= w_aden;
            r10_ua   <= (r9_y2 >> FRAC_BITS) << FRAC_BITS;
            r10_eps  <= r9_eps;
            if (r9_st == dpf_pkg::ST_OK && w_aden == 35'sd0) begin
                r10_st <= dpf_pkg::ST_ADEN;
            end else begin
                r10_st <= r9_st;
            end
        end
    end

    // stage 11: magnitude of the A denominator
    logic               r_v11;
    logic [33:0]        r11_ub;
    logic               r11_neg;
    logic [35:0]        r11_ua;
    logic signed [31:0] r11_eps;
    logic [2:0]         r11_st;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r11_ub  <= r10_aden[34] ? 34'(-r10_aden) : 34'(r10_aden);
            r11_neg <= r10_aden[34];
            r11_ua  <= r10_ua;
            r11_eps <= r10_eps;
            r11_st  <= r10_st;
        end
    end

    // stage 12: quotient too large for 32 bits
    logic            r_v12;
    logic [35:0]     r12_ua;
    logic [33:0]     r12_ub;
    dpf_pkg::t_tag_a r12_tag;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r12_ua  <= r11_ua;
            r12_ub  <= r11_ub;
            r12_tag <= '{neg: r11_neg, ovf: (66'(r11_ua) >= {r11_ub, 32'b0}),
                         eps: r11_eps, st: r11_st};
        end
    end

    // A magnitude
    logic            d3_vld;
    logic [31:0]     d3_q;
    dpf_pkg::t_tag_a d3_tag;

    dpf_div #(
        .NW (36),
        .DW (34),
        .QW (32),
        .TW ($bits(dpf_pkg::t_tag_a))
    ) u_div_a (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (r_v12),
        .i_dividend (r12_ua),
        .i_divisor  (r12_ub),
        .i_tag      (r12_tag),
        .o_valid    (d3_vld),
        .o_quotient (d3_q),
        .o_tag      (d3_tag)
    );

    // stage 13: saturate A
    logic               r_v13;
    logic signed [31:0] r13_a, r13_eps;
    logic [2:0]         r13_st;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r13_a   <= sat_mag(d3_tag.neg, d3_tag.ovf ? '1 : 64'(d3_q));
            r13_eps <= d3_tag.eps;
            r13_st  <= d3_tag.st;
        end
    end

    // stage 14: magnitudes and signs of the product operands
    logic signed [33:0] w_onep, w_onem;
    logic               r_v14;
    logic [31:0]        r14_ma, r14_me, r14_mp, r14_mm;
    logic               r14_sa, r14_se, r14_sp, r14_sm;
    logic signed [31:0] r14_a, r14_eps;
    logic [2:0]         r14_st;

    assign w_onep = 34'(ONE) + 34'(r13_eps);
    assign w_onem = 34'(ONE) - 34'(r13_eps);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r14_ma  <= r13_a[31] ? 32'(-r13_a) : 32'(r13_a);
            r14_me  <= r13_eps[31] ? 32'(-r13_eps) : 32'(r13_eps);
            r14_mp  <= w_onep[33] ? 32'(-w_onep) : 32'(w_onep);
            r14_mm  <= w_onem[33] ? 32'(-w_onem) : 32'(w_onem);
            r14_sa  <= r13_a[31];
            r14_se  <= r13_eps[31];
            r14_sp  <= w_onep[33];
            r14_sm  <= w_onem[33];
            r14_a   <= r13_a;
            r14_eps <= r13_eps;
            r14_st  <= r13_st;
        end
    end

    // stage 15: A eps, eps^2, eps (1 + eps), eps (1 - eps)
    logic               r_v15;
    logic [63:0]        r15_pab, r15_pee, r15_ppe, r15_pme;
    logic               r15_sb, r15_sv, r15_sw, r15_sa;
    logic [31:0]        r15_ma;
    logic signed [31:0] r15_a, r15_eps;
    logic [2:0]         r15_st;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r15_pab <= 64'(r14_ma) * 64'(r14_me);
            r15_pee <= 64'(r14_me) * 64'(r14_me);
            r15_ppe <= 64'(r14_me) * 64'(r14_mp);
            r15_pme <= 64'(r14_me) * 64'(r14_mm);
            r15_sb  <= r14_sa ^ r14_se;
            r15_sv  <= r14_se ^ r14_sp;
            r15_sw  <= r14_se ^ r14_sm;
            r15_sa  <= r14_sa;
            r15_ma  <= r14_ma;
            r15_a   <= r14_a;
            r15_eps <= r14_eps;
            r15_st  <= r14_st;
        end
    end

    // stage 16: B, radicands and their sign checks
    logic [63:0]     w_eem, w_vm, w_wm;
    logic            r_v16;
    logic [RDW-1:0]  r16_rad [3];
    dpf_pkg::t_side  r16_side;

    assign w_eem = r15_pee >> FRAC_BITS;
    assign w_vm  = r15_ppe >> (FRAC_BITS - 1);
    assign w_wm  = r15_pme >> (FRAC_BITS - 1);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r16_rad[0] <= RDW'(64'(ONE) - w_eem);
            r16_rad[1] <= (w_vm > LIM) ? LIM[RDW-1:0] : w_vm[RDW-1:0];
            r16_rad[2] <= (w_wm > LIM) ? LIM[RDW-1:0] : w_wm[RDW-1:0];
            r16_side   <= '{eps: r15_eps, a: r15_a,
                            b: sat_mag(r15_sb, r15_pab >> FRAC_BITS),
                            ma: r15_ma, sa: r15_sa, st: r15_st,
                            neg: {r15_sw && w_wm != 64'd0,
                                  r15_sv && w_vm != 64'd0,
                                  w_eem > 64'(ONE)}};
        end
    end

    // square root lanes, one root bit per stage
    logic [34:0]    r_sq_rem  [3][SQ_N];
    logic [31:0]    r_sq_root [3][SQ_N];
    logic [63:0]    r_sq_rad  [3][SQ_N];
    dpf_pkg::t_side r_sq_side [SQ_N];
    logic           r_sq_vld  [SQ_N];

    generate
        for (genvar k = 0; k < SQ_N; k++) begin : g_sq
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_sq_vld[k] <= 1'b0;
                end else if (w_en) begin
                    r_sq_vld[k] <= (k == 0) ? r_v16 : r_sq_vld[(k == 0) ? 0 : k-1];
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_sq_side[k] <= (k == 0) ? r16_side : r_sq_side[(k == 0) ? 0 : k-1];
                end
            end

            for (genvar j = 0; j < 3; j++) begin : g_lane
                logic [34:0] w_rem_in;
                logic [31:0] w_root_in;
                logic [63:0] w_rad_in;
                logic [34:0] w_rem2, w_trial;

                if (k == 0) begin : g_first
                    assign w_rem_in  = '0;
                    assign w_root_in = '0;
                    assign w_rad_in  = {1'b0, r16_rad[j], {FRAC_BITS{1'b0}}};
                end else begin : g_next
                    assign w_rem_in  = r_sq_rem[j][k-1];
                    assign w_root_in = r_sq_root[j][k-1];
                    assign w_rad_in  = r_sq_rad[j][k-1];
                end

                assign w_rem2  = {w_rem_in[32:0], w_rad_in[63:62]};
                assign w_trial = {1'b0, w_root_in, 2'b01};

                always_ff @(posedge i_clk) begin
                    if (w_en) begin
                        if (w_rem2 >= w_trial) begin
                            r_sq_rem[j][k]  <= w_rem2 - w_trial;
                            r_sq_root[j][k] <= {w_root_in[30:0], 1'b1};
                        end else begin
                            r_sq_rem[j][k]  <= w_rem2;
                            r_sq_root[j][k] <= {w_root_in[30:0], 1'b0};
                        end
                        r_sq_rad[j][k] <= w_rad_in << 2;
                    end
                end
            end
        end
    endgenerate

    // stage 17: |A| times each root
    logic           r_v17;
    logic [63:0]    r17_p [3];
    dpf_pkg::t_side r17_side;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 3; j++) begin
                r17_p[j] <= 64'(r_sq_side[SQ_N-1].ma) * 64'(r_sq_root[j][SQ_N-1]);
            end
            r17_side <= r_sq_side[SQ_N-1];
        end
    end

    // output register: rescale, saturate, mask and final status
    logic signed [31:0] w_f [3];
    logic               w_zero;
    logic [2:0]         w_st;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_f[j] = r17_side.neg[j] ? 32'sd0 : sat_mag(r17_side.sa, r17_p[j] >> FRAC_BITS);
        end
        w_zero = r17_side.st != dpf_pkg::ST_OK;
        if (!w_zero && r17_side.neg != 3'b000) begin
            w_st = dpf_pkg::ST_NEGRAD;
        end else begin
            w_st = r17_side.st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_epsilon_out <= w_zero ? 32'sd0 : r17_side.eps;
            o_factor_a    <= w_zero ? 32'sd0 : r17_side.a;
            o_factor_b    <= w_zero ? 32'sd0 : r17_side.b;
            o_factor_c    <= w_zero ? 32'sd0 : w_f[0];
            o_factor_v    <= w_zero ? 32'sd0 : w_f[1];
            o_factor_w    <= w_zero ? 32'sd0 : w_f[2];
            o_status      <= w_st;
        end
    end

    // valid bits travel with the items
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_v4    <= 1'b0;
            r_v5    <= 1'b0;
            r_v6    <= 1'b0;
            r_v7    <= 1'b0;
            r_v8    <= 1'b0;
            r_v9    <= 1'b0;
            r_v10   <= 1'b0;
            r_v11   <= 1'b0;
            r_v12   <= 1'b0;
            r_v13   <= 1'b0;
            r_v14   <= 1'b0;
            r_v15   <= 1'b0;
            r_v16   <= 1'b0;
            r_v17   <= 1'b0;
            o_valid <= 1'b0;
        end else if (w_en) begin
            r_v1    <= i_valid;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_v4    <= r_v3;
            r_v5    <= d1_vld;
            r_v6    <= r_v5;
            r_v7    <= r_v6;
            r_v8    <= r_v7;
            r_v9    <= d2_vld;
            r_v10   <= r_v9;
            r_v11   <= r_v10;
            r_v12   <= r_v11;
            r_v13   <= d3_vld;
            r_v14   <= r_v13;
            r_v15   <= r_v14;
            r_v16   <= r_v15;
            r_v17   <= r_sq_vld[SQ_N-1];
            o_valid <= r_v17;
        end
    end

    // an item rejected before the roots carries all zero values
    a_zero_on_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == dpf_pkg::ST_NOSEL || o_status == dpf_pkg::ST_Q2 ||
                     o_status == dpf_pkg::ST_EPSDEN || o_status == dpf_pkg::ST_ADEN))
        |-> (o_epsilon_out == 32'sd0 && o_factor_a == 32'sd0 && o_factor_b == 32'sd0 &&
             o_factor_c == 32'sd0 && o_factor_v == 32'sd0 && o_factor_w == 32'sd0))
        else $error("rejected item with nonzero values");

    // status stays within the defined codes
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status <= dpf_pkg::ST_NEGRAD))
        else $error("status code out of range");

    // a row that is not selected comes out with the matching status
    a_nosel_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r17_side.st == dpf_pkg::ST_NOSEL && w_en && r_v17)
        |=> (o_status == dpf_pkg::ST_NOSEL))
        else $error("unselected row lost its status");

endmodule
